>>> src/shl_pkg.sv
// Shared types, codes and helper functions of the command-line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package shl_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_RESULTS = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_QUOTE  = 2'd1,
		MODE_AMP    = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		TOK_WORD     = 4'd0,
		TOK_PIPE     = 4'd1,
		TOK_AMP      = 4'd2,
		TOK_ANDAND   = 4'd3,
		TOK_GT       = 4'd4,
		TOK_GTGT     = 4'd5,
		TOK_ERR_GT   = 4'd6,
		TOK_LT       = 4'd7,
		TOK_LTLT     = 4'd8,
		TOK_LTLTLT   = 4'd9
	} tok_type_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       is_char;
		logic       token_end;
		logic [3:0] token_type;
		logic       line_done;
		logic       quote_error;
		logic       last;
	} out_item_t;

	// One result without its last flag
	typedef struct packed {
		logic [7:0] out_char;
		logic       is_char;
		logic       token_end;
		logic [3:0] token_type;
		logic       line_done;
		logic       quote_error;
	} res_t;

	// All results caused by one item
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] recs;
		logic [2:0]             cnt;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} q_push_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} q_head_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [3:0] classify(input logic [2:0] len, input logic [23:0] pf);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [3:0] t;
		b0 = pf[7:0];
		b1 = pf[15:8];
		b2 = pf[23:16];
		t = TOK_WORD;
		if (len == 3'd1) begin
			if (b0 == CH_GT) t = TOK_GT;
			else if (b0 == CH_LT) t = TOK_LT;
		end else if (len == 3'd2) begin
			if (b0 == CH_GT && b1 == CH_GT) t = TOK_GTGT;
			else if (b0 == CH_TWO && b1 == CH_GT) t = TOK_ERR_GT;
			else if (b0 == CH_LT && b1 == CH_LT) t = TOK_LTLT;
		end else if (len == 3'd3) begin
			if (b0 == CH_LT && b1 == CH_LT && b2 == CH_LT) t = TOK_LTLTLT;
		end
		return t;
	endfunction

	function automatic res_t mk_char(input logic [7:0] c);
		res_t r;
		r = '0;
		r.out_char = c;
		r.is_char = 1'b1;
		return r;
	endfunction

	function automatic res_t mk_tok(input logic [3:0] t);
		res_t r;
		r = '0;
		r.token_end = 1'b1;
		r.token_type = t;
		return r;
	endfunction

	function automatic res_t mk_done(input logic qerr);
		res_t r;
		r = '0;
		r.line_done = 1'b1;
		r.quote_error = qerr;
		return r;
	endfunction

	function automatic bundle_t add_rec(input bundle_t b, input res_t r);
		bundle_t o;
		o = b;
		o.recs[b.cnt[1:0]] = r;
		o.cnt = b.cnt + 3'd1;
		return o;
	endfunction

endpackage
`default_nettype wire

>>> src/shl_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface shl_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/shell_command_line_tokenizer.sv
// Top level of the command-line tokenizer: front end, bundle queue, back end.
// Path: an accepted item's bundle is registered in the queue; its results are then registered one by one at the output.
// Throughput: one item per cycle while each item causes at most one result and the output is ready;
// an item with several results (up to four) holds the output sequencer until all are sent, one result at a time.
// Reset (arst_n low, asynchronous): normal mode, empty value, queue and output cleared.
`timescale 1ns / 1ps
`default_nettype none
module shell_command_line_tokenizer
	import shl_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	shl_stream_if.sink   cmd,
	shl_stream_if.source tok
);

	// Between front and queue: one bundle of results per accepted item that causes any
	q_push_t push;
	logic    q_full;
	// Between queue and back: head bundle and its release
	q_head_t head;
	logic    pop;

	// Front: keep lexer mode, value length and the first three bytes; turn each
	// item into all of its results at once.
	shl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_full (q_full),
		.push   (push)
	);

	// Queue: hold bundles so a stalled output does not stop the front at once.
	shl_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// Back: drain the head bundle one result per cycle while the output is ready, flag the last one.
	shl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tok    (tok)
	);

	// Each result carries exactly one kind of event
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid |-> $onehot({tok.data.is_char, tok.data.token_end, tok.data.line_done}))
		else $error("result carries not exactly one event kind");

	// Line end closes the item's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.data.line_done) |-> tok.data.last)
		else $error("line_done result not marked last");

	// Quote error only on the line end result
	a_qerr: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.data.quote_error) |-> tok.data.line_done)
		else $error("quote_error outside line_done");

	// A full queue stalls input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !cmd.ready)
		else $error("input ready while queue full");

endmodule
`default_nettype wire

>>> src/shl_front.sv
// Front end: lexer state and classification of each byte into a result bundle.
`timescale 1ns / 1ps
`default_nettype none
module shl_front
	import shl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	shl_stream_if.sink    cmd,
	input  wire logic     q_full,
	output q_push_t       push
);

	mode_t       mode_q;
	logic [2:0]  wl_q;
	logic [23:0] pf_q;

	mode_t       mode_d;
	logic [2:0]  wl_d;
	logic [23:0] pf_d;
	bundle_t     b;
	logic        take;

	assign cmd.ready = !q_full;
	assign take = cmd.valid && cmd.ready;

	always_comb begin
		logic [7:0] c;
		logic       norm;
		logic       qerr;
		c = cmd.data.char_code;
		mode_d = mode_q;
		wl_d = wl_q;
		pf_d = pf_q;
		b = '0;
		norm = 1'b0;
		qerr = 1'b0;

		if (cmd.data.char_valid) begin
			unique case (mode_q)
				MODE_QUOTE: begin
					if (c == CH_QUOTE) begin
						b = add_rec(b, mk_tok(classify(wl_d, pf_d)));
						wl_d = '0;
						pf_d = '0;
						mode_d = MODE_NORMAL;
					end else begin
						b = add_rec(b, mk_char(c));
						if (wl_d < 3'd3) pf_d[{wl_d[1:0], 3'b000} +: 8] = c;
						if (wl_d != 3'd7) wl_d = wl_d + 3'd1;
					end
				end
				MODE_AMP: begin
					mode_d = MODE_NORMAL;
					if (c == CH_AMP) begin
						b = add_rec(b, mk_tok(TOK_ANDAND));
					end else begin
						b = add_rec(b, mk_tok(TOK_AMP));
						norm = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_NORMAL;
					norm = 1'b1;
				end
			endcase

			if (norm) begin
				priority if (is_blank(c)) begin
					if (wl_d != 3'd0) begin
						b = add_rec(b, mk_tok(classify(wl_d, pf_d)));
						wl_d = '0;
						pf_d = '0;
					end
				end else if (c == CH_QUOTE) begin
					mode_d = MODE_QUOTE;
				end else if (c == CH_PIPE) begin
					if (wl_d != 3'd0) begin
						b = add_rec(b, mk_tok(classify(wl_d, pf_d)));
						wl_d = '0;
						pf_d = '0;
					end
					b = add_rec(b, mk_tok(TOK_PIPE));
				end else if (c == CH_AMP) begin
					if (wl_d != 3'd0) begin
						b = add_rec(b, mk_tok(classify(wl_d, pf_d)));
						wl_d = '0;
						pf_d = '0;
					end
					mode_d = MODE_AMP;
				end else begin
					b = add_rec(b, mk_char(c));
					if (wl_d < 3'd3) pf_d[{wl_d[1:0], 3'b000} +: 8] = c;
					if (wl_d != 3'd7) wl_d = wl_d + 3'd1;
				end
			end
		end

		if (cmd.data.line_end) begin
			if (mode_d == MODE_QUOTE) begin
				qerr = 1'b1;
			end else if (mode_d == MODE_AMP) begin
				b = add_rec(b, mk_tok(TOK_AMP));
			end else if (wl_d != 3'd0) begin
				b = add_rec(b, mk_tok(classify(wl_d, pf_d)));
			end
			b = add_rec(b, mk_done(qerr));
			mode_d = MODE_NORMAL;
			wl_d = '0;
			pf_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			wl_q <= '0;
			pf_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			wl_q <= wl_d;
			pf_q <= pf_d;
		end
	end

	// Push only items that cause at least one result
	assign push = '{valid: take && (b.cnt != 3'd0), bundle: b};

endmodule
`default_nettype wire

>>> src/shl_queue.sv
// Short bundle queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module shl_queue
	import shl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_push_t push,
	input  wire logic    pop,
	output logic         full,
	output q_head_t      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	bundle_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full = (cnt_q == CNT_FULL);
	assign do_push = push.valid && !full;
	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head = '{valid: (cnt_q != '0), bundle: mem_q[rd_ptr_q]};

endmodule
`default_nettype wire

>>> src/shl_back.sv
// Back end: step through a bundle one result per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps
`default_nettype none
module shl_back
	import shl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_head_t head,
	output logic         pop,
	shl_stream_if.source tok
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       load;
	logic       is_last;
	res_t       rec;

	assign load = head.valid && (!out_valid_q || tok.ready);
	assign rec = head.bundle.recs[idx_q];
	assign is_last = ({1'b0, idx_q} == (head.bundle.cnt - 3'd1));
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (tok.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= {rec, is_last};
	end

	assign tok.valid = out_valid_q;
	assign tok.data = out_q;

endmodule
`default_nettype wire

>>> sim/tb_shell_command_line_tokenizer.sv
// Self-checking testbench for the command-line tokenizer: random-paced stream in, event stream out.
`timescale 1ns / 1ps
module tb_shell_command_line_tokenizer;
	import shl_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 160;
	// Drop all idling once this few items are left to send.
	localparam int QUIET_TAIL   = 30;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 100000;

	logic clk;
	logic arst_n;

	shl_stream_if #(.T(in_item_t))  cmd_ch ();
	shl_stream_if #(.T(out_item_t)) tok_ch ();

	shell_command_line_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.tok    (tok_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Stimulus and scoreboard storage
	in_item_t  cmd_items[$];        // items still to be sent, filled at time zero
	out_item_t expected_events[$];  // token events predicted but not yet seen

	// Lexer state mirrored by the predictor
	mode_t       lex_state;
	logic [2:0]  val_len;   // bytes in the current value, saturates at 7
	logic [23:0] val_head;  // first three bytes of the value, first byte lowest

	int cmd_gap;
	int tok_gap;
	int random_count;
	int items_sent;
	int results_seen;
	int mismatches;
	int token_ends;
	int redirects;
	int lines_done;
	int quote_errors;
	int cycles;

	string redir_text [6] = '{">", ">>", "2>", "<", "<<", "<<<"};
	string word_chars = "abqz059_-.=/2<>";

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void emit_event(input logic [7:0] ch, input logic isch, input logic tend,
			input logic [3:0] ttype, input logic done, input logic qerr);
		out_item_t e;
		e = '0;
		e.out_char    = ch;
		e.is_char     = isch;
		e.token_end   = tend;
		e.token_type  = ttype;
		e.line_done   = done;
		e.quote_error = qerr;
		expected_events.insert(expected_events.size(), e);
	endfunction

	// Close the current value; a short value that spells one of the redirection
	// operators takes the matching redirection type.
	function automatic void close_value();
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		tok_type_t  kind;
		b0 = val_head[7:0];
		b1 = val_head[15:8];
		b2 = val_head[23:16];
		kind = TOK_WORD;
		case (val_len)
			3'd1: begin
				if (b0 == CH_GT) kind = TOK_GT;
				else if (b0 == CH_LT) kind = TOK_LT;
			end
			3'd2: begin
				if (b0 == CH_GT && b1 == CH_GT) kind = TOK_GTGT;
				else if (b0 == CH_TWO && b1 == CH_GT) kind = TOK_ERR_GT;
				else if (b0 == CH_LT && b1 == CH_LT) kind = TOK_LTLT;
			end
			3'd3: begin
				if (b0 == CH_LT && b1 == CH_LT && b2 == CH_LT) kind = TOK_LTLTLT;
			end
			default: ;
		endcase
		emit_event(8'h00, 1'b0, 1'b1, kind, 1'b0, 1'b0);
		val_len  = '0;
		val_head = '0;
	endfunction

	function automatic void add_byte(input logic [7:0] c);
		emit_event(c, 1'b1, 1'b0, TOK_WORD, 1'b0, 1'b0);
		if (val_len < 3'd3) val_head[8*val_len +: 8] = c;
		if (val_len < 3'd7) val_len = val_len + 3'd1;
	endfunction

	// Handle one byte outside quotes with no ampersand pending.
	function automatic void plain_byte(input logic [7:0] c);
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			if (val_len != 0) close_value();
		end else if (c == CH_QUOTE) begin
			lex_state = MODE_QUOTE;
		end else if (c == CH_PIPE) begin
			if (val_len != 0) close_value();
			emit_event(8'h00, 1'b0, 1'b1, TOK_PIPE, 1'b0, 1'b0);
		end else if (c == CH_AMP) begin
			if (val_len != 0) close_value();
			lex_state = MODE_AMP;
		end else begin
			add_byte(c);
		end
	endfunction

	// Advance the lexer by one accepted item and queue the events it causes.
	function automatic void lex_item(input in_item_t it);
		int        first;
		logic      qerr;
		out_item_t tail_ev;
		first = expected_events.size();
		if (it.char_valid) begin
			case (lex_state)
				MODE_QUOTE: begin
					if (it.char_code == CH_QUOTE) begin
						close_value();
						lex_state = MODE_NORMAL;
					end else begin
						add_byte(it.char_code);
					end
				end
				MODE_AMP: begin
					lex_state = MODE_NORMAL;
					if (it.char_code == CH_AMP) begin
						emit_event(8'h00, 1'b0, 1'b1, TOK_ANDAND, 1'b0, 1'b0);
					end else begin
						emit_event(8'h00, 1'b0, 1'b1, TOK_AMP, 1'b0, 1'b0);
						plain_byte(it.char_code);
					end
				end
				default: begin
					lex_state = MODE_NORMAL;
					plain_byte(it.char_code);
				end
			endcase
		end
		if (it.line_end) begin
			qerr = (lex_state == MODE_QUOTE);
			if (lex_state == MODE_AMP) emit_event(8'h00, 1'b0, 1'b1, TOK_AMP, 1'b0, 1'b0);
			else if (!qerr && val_len != 0) close_value();
			emit_event(8'h00, 1'b0, 1'b0, TOK_WORD, 1'b1, qerr);
			lex_state = MODE_NORMAL;
			val_len   = '0;
			val_head  = '0;
		end
		// Mark the final event of this item
		if (expected_events.size() > first) begin
			tail_ev = expected_events.pop_back();
			tail_ev.last = 1'b1;
			expected_events.insert(expected_events.size(), tail_ev);
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected result %h", got));
		end else begin
			want = expected_events.pop_front();
			check_field("out_char",    got.out_char,    want.out_char);
			check_field("is_char",     got.is_char,     want.is_char);
			check_field("token_end",   got.token_end,   want.token_end);
			check_field("token_type",  got.token_type,  want.token_type);
			check_field("line_done",   got.line_done,   want.line_done);
			check_field("quote_error", got.quote_error, want.quote_error);
			check_field("last",        got.last,        want.last);
			if (want.token_end) token_ends++;
			if (want.token_end && want.token_type >= TOK_GT) redirects++;
			if (want.line_done) lines_done++;
			if (want.quote_error) quote_errors++;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	task automatic add_item(input logic [7:0] c, input logic v, input logic le);
		in_item_t it;
		it.char_code  = c;
		it.char_valid = v;
		it.line_end   = le;
		cmd_items.insert(cmd_items.size(), it);
		if (v || le) random_count++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b1, 1'b0);
	endtask

	// Close the line on the most recently queued item.
	task automatic end_line();
		in_item_t it;
		it = cmd_items.pop_back();
		it.line_end = 1'b1;
		cmd_items.insert(cmd_items.size(), it);
	endtask

	function automatic logic [7:0] random_word_byte();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return word_chars[$urandom_range(0, word_chars.len() - 1)];
	endfunction

	// Build one command line: mostly well-formed tokens separated by blanks,
	// with some noise bytes, empty items and broken endings mixed in.
	task automatic add_random_line();
		int ntok;
		int kind;
		int len;
		int bsel;
		ntok = $urandom_range(1, 6);
		repeat (ntok) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
					repeat (len) add_item(random_word_byte(), 1'b1, 1'b0);
				end
				3: add_text(redir_text[$urandom_range(0, 5)]);
				4: add_item(CH_PIPE, 1'b1, 1'b0);
				5: add_item(CH_AMP, 1'b1, 1'b0);
				6: add_text("&&");
				7: begin
					add_item(CH_QUOTE, 1'b1, 1'b0);
					if ($urandom_range(0, 1) == 0)
						add_text(redir_text[$urandom_range(0, 5)]);
					else
						repeat ($urandom_range(0, 3)) add_item(random_word_byte(), 1'b1, 1'b0);
					add_item(CH_QUOTE, 1'b1, 1'b0);
				end
				8: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				default: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			endcase
			if ($urandom_range(0, 9) < 7) begin
				repeat ($urandom_range(1, 2)) begin
					bsel = $urandom_range(0, 5);
					add_item((bsel == 5) ? CH_SPACE : 8'(CH_TAB + bsel), 1'b1, 1'b0);
				end
			end
		end
		case ($urandom_range(0, 9))
			0: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			1: begin
				add_item(CH_QUOTE, 1'b1, 1'b0);
				add_item(random_word_byte(), 1'b1, 1'b1);
			end
			default: end_line();
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: hold each item until accepted, insert random idle bursts
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data  <= '0;
			cmd_gap      <= 0;
			lex_state    = MODE_NORMAL;
			val_len      = '0;
			val_head     = '0;
		end else begin
			// Predict on acceptance; results appear no earlier than the next edge
			if (cmd_ch.valid && cmd_ch.ready) begin
				lex_item(cmd_ch.data);
				items_sent++;
			end
			// Only advance once the current item is gone (or none is offered)
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_gap != 0) begin
					cmd_gap      <= cmd_gap - 1;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_items.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
					// Start an idle burst
					cmd_gap      <= $urandom_range(0, 6);
					cmd_ch.valid <= 1'b0;
				end else if (cmd_items.size() != 0) begin
					cmd_ch.data  <= cmd_items.pop_front();
					cmd_ch.valid <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted result, stall ready in random bursts
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
			tok_gap      <= 0;
		end else begin
			if (tok_ch.valid && tok_ch.ready)
				check_result(tok_ch.data);
			if (tok_gap != 0) begin
				tok_gap      <= tok_gap - 1;
				tok_ch.ready <= 1'b0;
			end else if (cmd_items.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
				tok_gap      <= $urandom_range(0, 6);
				tok_ch.ready <= 1'b0;
			end else begin
				tok_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles: %0d items unsent, %0d results outstanding",
				cycles, cmd_items.size(), expected_events.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build stimulus, reset, wait for drain, report
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		tok_ch.ready = 1'b0;

		// Directed lines: pipe, and-and, ampersand before a byte and at line end
		add_text("a|b&&c&d&");
		end_line();
		// Quote inside a word, then empty quotes closing the line
		add_text("x\"y z\" \"\"");
		end_line();
		// Item with neither byte nor line end: no result expected
		add_item(8'h5A, 1'b0, 1'b0);
		// Unterminated quote holding both byte extremes
		add_item(CH_QUOTE, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'h00, 1'b1, 1'b1);
		// Four-byte value is too long to be a redirection
		add_text("<<<<");
		end_line();
		// Bare line end with an empty lexer
		add_item(8'hA5, 1'b0, 1'b1);

		random_count = 0;
		while (random_count < RANDOM_ITEMS)
			add_random_line();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to be taken, then for every predicted event
		while (cmd_items.size() != 0 || cmd_ch.valid) @(posedge clk);
		while (expected_events.size() != 0) @(posedge clk);
		// Catch any stray result the block might still emit
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items over %0d cycles; checked %0d results", items_sent, cycles,
			results_seen);
		$display("covered %0d token ends (%0d redirections), %0d lines, %0d open-quote lines",
			token_ends, redirects, lines_done, quote_errors);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
src/shl_pkg.sv
src/shl_stream_if.sv
src/shl_front.sv
src/shl_queue.sv
src/shl_back.sv
src/shell_command_line_tokenizer.sv
sim/tb_shell_command_line_tokenizer.sv
